// File: src/trq_pkg.sv
// shared types and constants for the touch report qualifier
// no dependencies; used by every module of the block
package trq_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned HOLD_W  = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [7:0] FRAME_BAD_STATUS = 8'hFF;
  localparam logic [7:0] FRAME_TAIL       = 8'hAB;
  localparam logic [CNT_W-1:0] FRAME_FULL_BYTES = 3'd7;
  localparam logic [COORD_W-1:0] COORD_MAX = 12'hFFF;

  localparam logic [SIZE_W-1:0] SCREEN_W_RESET = 13'd4096;
  localparam logic [SIZE_W-1:0] SCREEN_H_RESET = 13'd4096;
  localparam logic [HOLD_W-1:0] HOLD_MS_RESET  = 10'd40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS          = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LINE_PRESENT = 8'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
    logic [HOLD_W-1:0] hold_ms;
    logic              int_line_present;
  } cfg_t;

  typedef struct packed {
    logic              int_level_low;
    logic [7:0]        status_byte;
    logic [7:0]        x_high_byte;
    logic [7:0]        y_high_byte;
    logic [7:0]        xy_low_byte;
    logic [7:0]        touch_count;
    logic [7:0]        tail_byte;
    logic [CNT_W-1:0]  bytes_received;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               pressed;
  } res_t;

endpackage

// File: src/trq_mirror.sv
// mirrors one raw coordinate against a screen size, clamps to the coordinate range
// depends on trq_pkg
module trq_mirror (
  input  logic [trq_pkg::COORD_W-1:0] raw,
  input  logic [trq_pkg::SIZE_W-1:0]  size,
  output logic [trq_pkg::COORD_W-1:0] coord
);

  logic [trq_pkg::SIZE_W-1:0] raw_ext;
  logic [trq_pkg::SIZE_W-1:0] diff;

  assign raw_ext = {1'b0, raw};
  // only used when size > raw, so never negative
  assign diff    = size - raw_ext - trq_pkg::SIZE_W'(1);

  always_comb begin
    if (size <= raw_ext) begin
      coord = '0;
    end else if (diff[trq_pkg::SIZE_W-1]) begin
      coord = trq_pkg::COORD_MAX;
    end else begin
      coord = diff[trq_pkg::COORD_W-1:0];
    end
  end

endmodule

// File: src/trq_core.sv
// frame check, held-press state and result selection for one poll
// depends on trq_pkg and trq_mirror
module trq_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  trq_pkg::item_t item,
  input  trq_pkg::cfg_t  cfg,
  output trq_pkg::res_t  res
);

  logic [trq_pkg::COORD_W-1:0] held_x_r, held_x_nxt;
  logic [trq_pkg::COORD_W-1:0] held_y_r, held_y_nxt;
  logic                        held_pressed_r, held_pressed_nxt;
  logic [trq_pkg::TIME_W-1:0]  last_assert_r, last_assert_nxt;

  logic                        asserted;
  logic                        good;
  logic                        in_hold;
  logic [trq_pkg::COORD_W-1:0] raw_x, raw_y, mir_x, mir_y;
  logic [trq_pkg::TIME_W-1:0]  elapsed;

  assign raw_x = {item.x_high_byte, item.xy_low_byte[7:4]};
  assign raw_y = {item.y_high_byte, item.xy_low_byte[3:0]};

  trq_mirror u_mirror_x (.raw(raw_x), .size(cfg.screen_width),  .coord(mir_x));
  trq_mirror u_mirror_y (.raw(raw_y), .size(cfg.screen_height), .coord(mir_y));

  assign asserted = !cfg.int_line_present || item.int_level_low;
  assign good = (item.bytes_received == trq_pkg::FRAME_FULL_BYTES) &&
                (item.status_byte != trq_pkg::FRAME_BAD_STATUS) &&
                (item.touch_count != 8'd0) &&
                (item.tail_byte == trq_pkg::FRAME_TAIL);
  // wrapping time difference
  assign elapsed = item.now_ms - last_assert_r;
  assign in_hold = held_pressed_r &&
                   (elapsed < {{(trq_pkg::TIME_W-trq_pkg::HOLD_W){1'b0}}, cfg.hold_ms});

  always_comb begin
    held_x_nxt       = held_x_r;
    held_y_nxt       = held_y_r;
    held_pressed_nxt = held_pressed_r;
    last_assert_nxt  = last_assert_r;
    res              = '0;
    if (asserted) begin
      last_assert_nxt = item.now_ms;
      if (good) begin
        held_x_nxt       = mir_x;
        held_y_nxt       = mir_y;
        held_pressed_nxt = 1'b1;
      end
      res.point_x = held_x_nxt;
      res.point_y = held_y_nxt;
      res.pressed = held_pressed_nxt;
    end else if (in_hold) begin
      res.point_x = held_x_r;
      res.point_y = held_y_r;
      res.pressed = 1'b1;
    end else begin
      held_pressed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_pressed_r <= 1'b0;
      last_assert_r  <= '0;
    end else if (step) begin
      held_x_r       <= held_x_nxt;
      held_y_r       <= held_y_nxt;
      held_pressed_r <= held_pressed_nxt;
      last_assert_r  <= last_assert_nxt;
    end
  end

endmodule

// File: src/touch_report_qualifier_top.sv
// top level of the touch report qualifier: stream ports, config registers, pipeline
// depends on trq_pkg and trq_core
//
// Every input word is one poll of a touch controller and gives exactly one
// result word (point_x, point_y, pressed). The block takes one word per
// clock: a poll is caught in an input register, qualified by a single pass of
// compare, mirror and subtract logic against the held-press state, and
// the result lands in an output register. A new poll may enter every cycle
// while out_tready stays high. Back-pressure on the result side stalls both
// registers; the input still accepts a word as long as the input register is
// empty or about to drain. The interrupt line counts as asserted when
// int_level_low is set or when int_line_present is 0.
// Good frames update the held point; while the line is released a held press
// repeats for hold_ms milliseconds (wrapping time difference) and then
// reports (0,0,released). Configuration writes are always accepted and take
// effect on the next poll; write them only while no poll is in flight.
module touch_report_qualifier_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, low bit up: int_level_low, status_byte, x_high_byte, y_high_byte,
  // xy_low_byte, touch_count, tail_byte, bytes_received, now_ms, zero pad
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [trq_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata, low bit up: point_x, point_y, pressed, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [trq_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [trq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  trq_pkg::cfg_t  cfg_r;
  trq_pkg::item_t in_item;
  trq_pkg::item_t s1_item_r;
  logic           s1_valid_r, s1_valid_nxt;
  trq_pkg::res_t  core_res;
  trq_pkg::res_t  out_res_r;
  logic           out_valid_r, out_valid_nxt;
  logic           advance;
  logic           in_fire;
  logic           step;

  // unpack the input word
  assign in_item.int_level_low  = in_tdata[0];
  assign in_item.status_byte    = in_tdata[8:1];
  assign in_item.x_high_byte    = in_tdata[16:9];
  assign in_item.y_high_byte    = in_tdata[24:17];
  assign in_item.xy_low_byte    = in_tdata[32:25];
  assign in_item.touch_count    = in_tdata[40:33];
  assign in_item.tail_byte      = in_tdata[48:41];
  assign in_item.bytes_received = in_tdata[51:49];
  assign in_item.now_ms         = in_tdata[83:52];

  // config registers, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width     <= trq_pkg::SCREEN_W_RESET;
      cfg_r.screen_height    <= trq_pkg::SCREEN_H_RESET;
      cfg_r.hold_ms          <= trq_pkg::HOLD_MS_RESET;
      cfg_r.int_line_present <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        trq_pkg::CFG_SCREEN_WIDTH:     cfg_r.screen_width  <= cfg_data;
        trq_pkg::CFG_SCREEN_HEIGHT:    cfg_r.screen_height <= cfg_data;
        trq_pkg::CFG_HOLD_MS:          cfg_r.hold_ms <= cfg_data[trq_pkg::HOLD_W-1:0];
        trq_pkg::CFG_INT_LINE_PRESENT: cfg_r.int_line_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // pipeline control: output register drains or is empty -> stage 1 moves
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign step      = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  // qualification logic and held-press state, updated once per poll
  trq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.pressed, out_res_r.point_y, out_res_r.point_x};

endmodule

// File: src/trq_checker.sv
// port-level checks for the touch report qualifier, bound to the top level
// depends on touch_report_qualifier_top ports only
module trq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [trq_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // nothing comes out right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty output side never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a word taken while the output is empty shows up after passing the input and output registers
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing two cycles after accept");

endmodule

bind touch_report_qualifier_top trq_checker u_trq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/trq_report_checker.sv
// report checker for the touch report qualifier: predicts each report from the polls
// and config writes it sees on the ports, then compares against the result stream
// depends on trq_pkg
module trq_report_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [trq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [trq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [trq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             reports_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  trq_pkg::cfg_t               settings;
  logic [trq_pkg::COORD_W-1:0] held_x;
  logic [trq_pkg::COORD_W-1:0] held_y;
  logic                        held_pressed;
  logic [trq_pkg::TIME_W-1:0]  last_assert_ms;
  trq_pkg::res_t               expected_reports[$];

  // mirror against the screen size, zero at or past the edge, saturate on oversized screens
  function automatic logic [trq_pkg::COORD_W-1:0] flip_axis(
      logic [trq_pkg::COORD_W-1:0] raw, logic [trq_pkg::SIZE_W-1:0] span);
    logic [trq_pkg::SIZE_W-1:0] m;
    if (span <= {1'b0, raw}) return '0;
    m = span - 13'd1 - {1'b0, raw};
    if (m > {1'b0, trq_pkg::COORD_MAX}) return trq_pkg::COORD_MAX;
    return m[trq_pkg::COORD_W-1:0];
  endfunction

  function automatic trq_pkg::res_t qualify_poll(trq_pkg::item_t p);
    trq_pkg::res_t               r;
    logic                        frame_ok;
    logic [trq_pkg::COORD_W-1:0] raw_x;
    logic [trq_pkg::COORD_W-1:0] raw_y;
    logic [trq_pkg::TIME_W-1:0]  elapsed;
    r = '0;
    elapsed = p.now_ms - last_assert_ms;
    if (!settings.int_line_present || p.int_level_low) begin
      last_assert_ms = p.now_ms;
      frame_ok = (p.bytes_received == trq_pkg::FRAME_FULL_BYTES) &&
                 (p.status_byte != trq_pkg::FRAME_BAD_STATUS) &&
                 (p.touch_count != 8'd0) && (p.tail_byte == trq_pkg::FRAME_TAIL);
      if (frame_ok) begin
        raw_x = {p.x_high_byte, p.xy_low_byte[7:4]};
        raw_y = {p.y_high_byte, p.xy_low_byte[3:0]};
        held_x = flip_axis(raw_x, settings.screen_width);
        held_y = flip_axis(raw_y, settings.screen_height);
        held_pressed = 1'b1;
      end
      r.point_x = held_x;
      r.point_y = held_y;
      r.pressed = held_pressed;
    end else if (held_pressed &&
                 elapsed < {{(trq_pkg::TIME_W-trq_pkg::HOLD_W){1'b0}}, settings.hold_ms}) begin
      r.point_x = held_x;
      r.point_y = held_y;
      r.pressed = 1'b1;
    end else begin
      held_pressed = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    trq_pkg::item_t poll;
    trq_pkg::res_t  got;
    trq_pkg::res_t  want;
    int             errs;
    errs = 0;
    if (!rst_n) begin
      settings.screen_width     = trq_pkg::SCREEN_W_RESET;
      settings.screen_height    = trq_pkg::SCREEN_H_RESET;
      settings.hold_ms          = trq_pkg::HOLD_MS_RESET;
      settings.int_line_present = 1'b1;
      held_x         = '0;
      held_y         = '0;
      held_pressed   = 1'b0;
      last_assert_ms = '0;
      expected_reports.delete();
      mismatch_count <= 0;
      reports_owed   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trq_pkg::CFG_SCREEN_WIDTH:     settings.screen_width = cfg_data;
          trq_pkg::CFG_SCREEN_HEIGHT:    settings.screen_height = cfg_data;
          trq_pkg::CFG_HOLD_MS:          settings.hold_ms = cfg_data[trq_pkg::HOLD_W-1:0];
          trq_pkg::CFG_INT_LINE_PRESENT: settings.int_line_present = cfg_data[0];
          default: ;
        endcase
      end
      // results first, so a stray report never pairs with a poll taken on the same edge
      if (out_tvalid && out_tready) begin
        got.point_x = out_tdata[11:0];
        got.point_y = out_tdata[23:12];
        got.pressed = out_tdata[24];
        if (expected_reports.size() == 0) begin
          $error("report with no poll pending: point_x %0d point_y %0d pressed %0d",
                 got.point_x, got.point_y, got.pressed);
          errs++;
        end else begin
          want = expected_reports.pop_front();
          if (got.point_x !== want.point_x) begin
            $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
            errs++;
          end
          if (got.point_y !== want.point_y) begin
            $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
            errs++;
          end
          if (got.pressed !== want.pressed) begin
            $error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        poll.int_level_low  = in_tdata[0];
        poll.status_byte    = in_tdata[8:1];
        poll.x_high_byte    = in_tdata[16:9];
        poll.y_high_byte    = in_tdata[24:17];
        poll.xy_low_byte    = in_tdata[32:25];
        poll.touch_count    = in_tdata[40:33];
        poll.tail_byte      = in_tdata[48:41];
        poll.bytes_received = in_tdata[51:49];
        poll.now_ms         = in_tdata[83:52];
        expected_reports.push_back(qualify_poll(poll));
      end
      mismatch_count <= mismatch_count + errs;
      reports_owed   <= expected_reports.size();
    end
  end

endmodule

// File: test/touch_report_qualifier_top_test.sv
// testbench top for the touch report qualifier: drives polls and config writes,
// randomizes back-pressure, and gives the verdict
// depends on trq_pkg, trq_report_checker and touch_report_qualifier_top
module touch_report_qualifier_top_test ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  // indexes past the register list; writes there must change nothing
  localparam logic [trq_pkg::CFG_IDX_W-1:0] CFG_PAST_END  =
    trq_pkg::CFG_INT_LINE_PRESENT + 8'd1;
  localparam logic [trq_pkg::CFG_IDX_W-1:0] CFG_INDEX_TOP = '1;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [trq_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [trq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [trq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [trq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int          mismatch_count;
  int          reports_owed;
  int          cycle_count;
  // percent of cycles the sender idles / the receiver stalls
  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  // tb copy of the live settings, only used to shape stimulus
  int unsigned scr_w = 4096;
  int unsigned scr_h = 4096;
  int unsigned hold_now = 40;
  logic [31:0] stamp_ms = 32'd100;

  always #2 clk = ~clk;

  touch_report_qualifier_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  trq_report_checker report_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .reports_owed   (reports_owed)
  );

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= sink_stall);
  end

  // one poll word; random idle cycles ahead of it, valid stays up afterwards
  // so consecutive words can go back to back
  task automatic send_poll(input logic lvl, input logic [7:0] status,
                           input logic [7:0] xh, input logic [7:0] yh,
                           input logic [7:0] xyl, input logic [7:0] cnt,
                           input logic [7:0] tail, input logic [2:0] nrx,
                           input logic [31:0] stamp);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    // low bit up: int_level_low, status, x high, y high, xy low, count, tail,
    // bytes received, timestamp, zero pad
    in_tdata  = {4'd0, stamp, nrx, tail, cnt, xyl, yh, xh, status, lvl};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding report come back
  task automatic drain_reports();
    in_tvalid = 1'b0;
    wait (reports_owed == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [trq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [trq_pkg::CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // full register set; only called with nothing in flight
  task automatic configure(input int unsigned w, input int unsigned h,
                           input logic [trq_pkg::CFG_DATA_W-1:0] hold, input logic present);
    write_reg(trq_pkg::CFG_SCREEN_WIDTH, w[trq_pkg::CFG_DATA_W-1:0]);
    write_reg(trq_pkg::CFG_SCREEN_HEIGHT, h[trq_pkg::CFG_DATA_W-1:0]);
    write_reg(trq_pkg::CFG_HOLD_MS, hold);
    write_reg(trq_pkg::CFG_INT_LINE_PRESENT, {12'd0, present});
    cfg_valid = 1'b0;
    scr_w    = w;
    scr_h    = h;
    hold_now = 32'(hold[trq_pkg::HOLD_W-1:0]);
  endtask

  // raw coordinate, often right around the screen edge where mirroring clamps
  function automatic logic [11:0] pick_raw(int unsigned span);
    int v;
    if ($urandom_range(2) == 0) begin
      v = int'(span) - 1 + int'($urandom_range(0, 2));
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
    end else begin
      v = int'($urandom_range(0, 4095));
    end
    return v[11:0];
  endfunction

  // bursts of one poll kind, so presses, holds and releases form real sequences
  task automatic run_random(input int count);
    int          sent;
    int unsigned kind;
    int unsigned len;
    logic [11:0] rx;
    logic [11:0] ry;
    logic [7:0]  status;
    logic [7:0]  cnt;
    logic [7:0]  tail;
    logic [2:0]  nrx;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      len  = $urandom_range(1, 8);
      repeat (len) begin
        // small steps walk through the hold window, rare big jumps wrap the clock
        if ($urandom_range(19) == 0) stamp_ms += $urandom;
        else stamp_ms += $urandom_range(0, hold_now / 4 + 3);
        rx = pick_raw(scr_w);
        ry = pick_raw(scr_h);
        status = 8'($urandom_range(0, 254));
        cnt    = 8'($urandom_range(1, 255));
        tail   = trq_pkg::FRAME_TAIL;
        nrx    = trq_pkg::FRAME_FULL_BYTES;
        if (kind < 45) begin
          send_poll(1'b1, status, rx[11:4], ry[11:4], {rx[3:0], ry[3:0]},
                    cnt, tail, nrx, stamp_ms);
        end else if (kind < 75) begin
          // line released, frame bytes are junk
          send_poll(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 3'($urandom), stamp_ms);
        end else if (kind < 92) begin
          // one defect in an otherwise good frame
          case ($urandom_range(3))
            0: nrx = 3'($urandom_range(0, 6));
            1: status = trq_pkg::FRAME_BAD_STATUS;
            2: cnt = 8'd0;
            default: begin
              tail = 8'($urandom);
              if (tail == trq_pkg::FRAME_TAIL) tail = tail ^ 8'h01;
            end
          endcase
          send_poll(1'b1, status, rx[11:4], ry[11:4], {rx[3:0], ry[3:0]},
                    cnt, tail, nrx, stamp_ms);
        end else begin
          send_poll(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom), stamp_ms);
        end
        sent++;
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned w, input int unsigned h,
                           input logic [trq_pkg::CFG_DATA_W-1:0] hold, input logic present,
                           input int count);
    drain_reports();
    src_idle   = idle_pct;
    sink_stall = stall_pct;
    configure(w, h, hold, present);
    run_random(count / 2);
    // sender holds off mid-phase until every report is back
    drain_reports();
    run_random(count - count / 2);
  endtask

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed polls under reset settings (4096 x 4096, hold 40, line fitted)
    // released with nothing stored, then a bad frame with nothing stored
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'd100);
    send_poll(1'b1, trq_pkg::FRAME_BAD_STATUS, 8'h12, 8'h34, 8'h56, 8'h01,
              trq_pkg::FRAME_TAIL, trq_pkg::FRAME_FULL_BYTES, 32'd110);
    // raw corners, then a mid point
    send_poll(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd120);
    send_poll(1'b1, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd130);
    send_poll(1'b1, 8'h5A, 8'h80, 8'h7F, 8'hA5, 8'h02, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd140);
    // hold window: one ms short of hold, exactly hold, past it
    send_poll(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 32'd179);
    send_poll(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 32'd180);
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'd181);
    // bad frames after release: stored point, pressed clear
    send_poll(1'b1, 8'h01, 8'h10, 8'h20, 8'h33, 8'h00, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd200);
    send_poll(1'b1, 8'h01, 8'h10, 8'h20, 8'h33, 8'h01, 8'hAA,
              trq_pkg::FRAME_FULL_BYTES, 32'd210);
    send_poll(1'b1, 8'h01, 8'h10, 8'h20, 8'h33, 8'h01, trq_pkg::FRAME_TAIL, 3'd6, 32'd220);
    send_poll(1'b1, 8'h01, 8'h10, 8'h20, 8'h33, 8'h01, trq_pkg::FRAME_TAIL, 3'd0, 32'd230);
    // press just before the timestamp wraps, release across the wrap
    send_poll(1'b1, 8'h7F, 8'h3C, 8'hC3, 8'h96, 8'h80, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'hFFFF_FFF0);
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'h0000_0005);
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'h0000_0017);
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'h8000_0000);
    send_poll(1'b1, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'hFFFF_FFFF);
    drain_reports();

    // writes past the register list must be dropped
    write_reg(CFG_PAST_END, 13'd0);
    write_reg(CFG_INDEX_TOP, 13'd0);
    // zero width, widest height, no hold
    configure(0, 8191, 13'd0, 1'b1);
    send_poll(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd1000);
    send_poll(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h01, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd1001);
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'd1001);
    drain_reports();

    // no interrupt line: a high level still counts as asserted
    configure(4097, 1, 13'd1000, 1'b0);
    send_poll(1'b0, 8'h00, 8'hFF, 8'h00, 8'hF0, 8'h01, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd2000);
    send_poll(1'b0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, trq_pkg::FRAME_TAIL,
              trq_pkg::FRAME_FULL_BYTES, 32'd5000);
    send_poll(1'b0, trq_pkg::FRAME_BAD_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              3'd0, 32'd9000);

    // random phases: none idle, sender idle, receiver stalled, both
    run_phase(0, 0, 4096, 4096, 13'd40, 1'b1, 370);
    // upper hold bits set above the register width must be dropped
    run_phase(63, 0, 800, 480, 13'h1C00 | 13'd1000, 1'b1, 370);
    run_phase(0, 63, 8191, 0, 13'd0, 1'b1, 370);
    run_phase(21, 21, 320, 4097, 13'd7, 1'b0, 370);

    drain_reports();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && reports_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: touch_report_qualifier_top.f
src/trq_pkg.sv
src/trq_mirror.sv
src/trq_core.sv
src/touch_report_qualifier_top.sv
src/trq_checker.sv
test/trq_report_checker.sv
test/touch_report_qualifier_top_test.sv
